// File: src/pldm_pkg.sv
// Package for the piecewise-linear dial mapping: breakpoint table, widths and
// per-segment constants (slope and reciprocal of the knot span).
// No dependencies.
package pldm_pkg;

   // Table shape and fixed-point scaling
   localparam int TABLE_POINTS     = 15;
   localparam int TABLE_SLOTS      = 16;
   localparam int FRACTION_BITS    = 4;
   localparam int ANGLE_SCALE_BITS = 4;

   // Field and datapath widths
   localparam int SEG_W   = 4;
   localparam int X_W     = 13;
   localparam int ANGLE_W = 13;
   localparam int DIFF_W  = 10;   // offset into a segment, at most its span (800)
   localparam int SLOPE_W = 10;   // angle rise of one segment, 1/16 degree
   localparam int PROD_W  = 19;   // offset times rise, below 2**19
   localparam int RECIP_W = 21;   // ceil(2**RECIP_SHIFT / span), span at least 320
   localparam int QUOT_W  = 10;   // interpolated rise, at most SLOPE_W bits
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_ONE   = 2 ** RECIP_SHIFT;

   // Breakpoints in whole knots and whole degrees; unused slots are zero
   localparam int unsigned KNOTS_TBL [TABLE_SLOTS] = '{
      60, 80, 100, 120, 140, 160, 180, 200, 230, 250, 300, 350, 400, 450, 500, 0
   };
   localparam int unsigned DEGREES_TBL [TABLE_SLOTS] = '{
      3, 28, 55, 80, 105, 130, 155, 180, 213, 235, 262, 282, 300, 316, 330, 0
   };

   // Rounded-up reciprocal of each segment's span in 1/16 knot; exact quotient
   // for every product below 2**PROD_W since span stays below 2**(29-19)
   localparam int unsigned SEG_RECIP [TABLE_SLOTS] = '{
      (RECIP_ONE + 319) / 320, (RECIP_ONE + 319) / 320, (RECIP_ONE + 319) / 320,
      (RECIP_ONE + 319) / 320, (RECIP_ONE + 319) / 320, (RECIP_ONE + 319) / 320,
      (RECIP_ONE + 319) / 320, (RECIP_ONE + 479) / 480, (RECIP_ONE + 319) / 320,
      (RECIP_ONE + 799) / 800, (RECIP_ONE + 799) / 800, (RECIP_ONE + 799) / 800,
      (RECIP_ONE + 799) / 800, (RECIP_ONE + 799) / 800, 0, 0
   };

   // Saturation flags carried down the pipeline
   typedef struct packed {
      logic low;
      logic high;
   } clip_type;

   // Breakpoint airspeed in 1/16 knot
   function automatic logic [X_W-1:0] point_knots(input logic [SEG_W-1:0] idx);
      return X_W'(KNOTS_TBL[idx] << FRACTION_BITS);
   endfunction

   // Breakpoint angle in 1/16 degree
   function automatic logic [ANGLE_W-1:0] point_angle(input logic [SEG_W-1:0] idx);
      return ANGLE_W'(DEGREES_TBL[idx] << ANGLE_SCALE_BITS);
   endfunction

   // Angle rise across a segment in 1/16 degree
   function automatic logic [SLOPE_W-1:0] seg_slope(input logic [SEG_W-1:0] idx);
      logic [SEG_W-1:0] nxt;
      nxt = idx + 1'b1;
      return SLOPE_W'((DEGREES_TBL[nxt] - DEGREES_TBL[idx]) << ANGLE_SCALE_BITS);
   endfunction

   // Reciprocal of a segment's span
   function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] idx);
      return RECIP_W'(SEG_RECIP[idx]);
   endfunction

endpackage

// File: src/piecewise_linear_dial_mapping.sv
// Airspeed to dial angle through a fixed breakpoint table, linear between points.
// Depends on pldm_pkg for the table, widths and per-segment constants.
//
// Usage: the block takes one airspeed item in every clock cycle; busy is always
// low. Each item gives one dial angle on rsp_dial_angle with rsp_valid high for
// one cycle, in the order taken.
// The pipeline has five register stages: segment search,
// offset into the segment, slope multiply, reciprocal multiply in place of the
// divide by the segment span, and the final add with end-point saturation.
// Results cannot be held off, so nothing in the block ever waits.
module piecewise_linear_dial_mapping (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [pldm_pkg::X_W-1:0]     req_airspeed,
   output logic                         rsp_valid,
   output logic [pldm_pkg::ANGLE_W-1:0] rsp_dial_angle
);

   localparam logic [pldm_pkg::SEG_W-1:0] FIRST_IDX = '0;
   localparam logic [pldm_pkg::SEG_W-1:0] LAST_IDX  =
      pldm_pkg::SEG_W'(pldm_pkg::TABLE_POINTS - 1);
   localparam logic [pldm_pkg::SEG_W-1:0] LAST_SEG  =
      pldm_pkg::SEG_W'(pldm_pkg::TABLE_POINTS - 2);

   logic [pldm_pkg::X_W-1:0]     knots_first;
   logic [pldm_pkg::X_W-1:0]     knots_last;
   logic [pldm_pkg::ANGLE_W-1:0] angle_first;
   logic [pldm_pkg::ANGLE_W-1:0] angle_last;

   // Stage registers
   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                          rsp_valid_ff;
   logic [pldm_pkg::X_W-1:0]      s1_x_ff;
   logic [pldm_pkg::SEG_W-1:0]    s1_seg_ff, s2_seg_ff, s3_seg_ff, s4_seg_ff;
   pldm_pkg::clip_type            s1_clip_ff, s2_clip_ff, s3_clip_ff, s4_clip_ff;
   logic [pldm_pkg::DIFF_W-1:0]   s2_diff_ff;
   logic [pldm_pkg::PROD_W-1:0]   s3_prod_ff;
   logic [pldm_pkg::QUOT_W-1:0]   s4_quot_ff;
   logic [pldm_pkg::ANGLE_W-1:0]  rsp_angle_ff;

   // Next values
   logic [pldm_pkg::SEG_W-1:0]    s1_seg_in;
   pldm_pkg::clip_type            s1_clip_in;
   logic [pldm_pkg::X_W-1:0]      s2_full_diff;
   logic [pldm_pkg::DIFF_W-1:0]   s2_diff_in;
   logic [pldm_pkg::DIFF_W+pldm_pkg::SLOPE_W-1:0]  s3_full_prod;
   logic [pldm_pkg::PROD_W-1:0]   s3_prod_in;
   logic [pldm_pkg::PROD_W+pldm_pkg::RECIP_W-1:0]  s4_full_prod;
   logic [pldm_pkg::QUOT_W-1:0]   s4_quot_in;
   logic [pldm_pkg::ANGLE_W-1:0]  rsp_angle_in;

   assign knots_first = pldm_pkg::point_knots(FIRST_IDX);
   assign knots_last  = pldm_pkg::point_knots(LAST_IDX);
   assign angle_first = pldm_pkg::point_angle(FIRST_IDX);
   assign angle_last  = pldm_pkg::point_angle(LAST_IDX);

   // Never stall the sender
   assign busy = 1'b0;

   // Stage 1: find the segment, the last inner breakpoint strictly below x
   always_comb begin
      s1_seg_in = FIRST_IDX;
      for (int j = 1; j < pldm_pkg::TABLE_POINTS - 1; j++) begin
         if (req_airspeed > pldm_pkg::point_knots(pldm_pkg::SEG_W'(j))) begin
            s1_seg_in = pldm_pkg::SEG_W'(j);
         end
      end
      s1_clip_in.low  = (req_airspeed <= knots_first);
      s1_clip_in.high = (req_airspeed >= knots_last);
   end

   // Stage 2: offset into the segment, at most the span
   assign s2_full_diff = s1_x_ff - pldm_pkg::point_knots(s1_seg_ff);
   assign s2_diff_in   = s2_full_diff[pldm_pkg::DIFF_W-1:0];

   // Stage 3: offset times angle rise
   assign s3_full_prod = s2_diff_ff * pldm_pkg::seg_slope(s2_seg_ff);
   assign s3_prod_in   = s3_full_prod[pldm_pkg::PROD_W-1:0];

   // Stage 4: divide by the span through its reciprocal
   assign s4_full_prod = s3_prod_ff * pldm_pkg::seg_recip(s3_seg_ff);
   assign s4_quot_in   = pldm_pkg::QUOT_W'(s4_full_prod >> pldm_pkg::RECIP_SHIFT);

   // Stage 5: add the start angle, saturate at the table ends
   always_comb begin
      priority if (s4_clip_ff.low) begin
         rsp_angle_in = angle_first;
      end else if (s4_clip_ff.high) begin
         rsp_angle_in = angle_last;
      end else begin
         rsp_angle_in = pldm_pkg::point_angle(s4_seg_ff) +
                        pldm_pkg::ANGLE_W'(s4_quot_ff);
      end
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      s1_x_ff      <= req_airspeed;
      s1_seg_ff    <= s1_seg_in;
      s1_clip_ff   <= s1_clip_in;
      s2_diff_ff   <= s2_diff_in;
      s2_seg_ff    <= s1_seg_ff;
      s2_clip_ff   <= s1_clip_ff;
      s3_prod_ff   <= s3_prod_in;
      s3_seg_ff    <= s2_seg_ff;
      s3_clip_ff   <= s2_clip_ff;
      s4_quot_ff   <= s4_quot_in;
      s4_seg_ff    <= s3_seg_ff;
      s4_clip_ff   <= s3_clip_ff;
      rsp_angle_ff <= rsp_angle_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dial_angle = rsp_angle_ff;

`ifndef ASSERT_OFF
   // Every accepted item comes out after the full pipeline
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##5 rsp_valid)
      else $error("accepted item did not produce a result");

   // No result without a matching accepted item
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without an accepted item");

   // Results stay within the end angles of the table
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dial_angle >= angle_first) && (rsp_dial_angle <= angle_last))
      else $error("dial angle outside table range");

   // Samples at or below the first breakpoint give the first angle
   a_low_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_airspeed <= knots_first, 5) |-> rsp_dial_angle == angle_first)
      else $error("low saturation wrong");

   // Segment index never passes the last segment
   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_seg_ff <= LAST_SEG)
      else $error("segment index out of range");
`endif

endmodule
